### sv/entity_snapshot_interpolator_top_assert.svh
// assertion macros for the entity snapshot interpolator top level
// expects clock and reset in the scope of each use
`ifndef ENTITY_SNAPSHOT_INTERPOLATOR_TOP_ASSERT_SVH
`define ENTITY_SNAPSHOT_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define ESI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esi assertion failed");

// implication after a fixed number of cycles
`define ESI_ASSERT_DLY(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("esi delayed assertion failed");

`endif

### sv/esi_pkg.sv
// shared types, constants and helpers of the entity snapshot interpolator
// no dependencies
`default_nettype none

package esi_pkg;

   localparam int COORD_BITS     = 21;
   localparam int TIME_FRAC_BITS = 12;
   localparam int POS_W          = 3 * COORD_BITS;
   localparam int T_W            = 16;
   localparam int YAW_W          = 16;
   localparam int DIST_W         = 20;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 20;

   localparam logic [T_W-1:0] ONE_T     = T_W'(1 << TIME_FRAC_BITS);
   localparam logic [T_W-1:0] STALE_AGE = T_W'(2 << TIME_FRAC_BITS);
   // intervals at or below one millisecond
   localparam logic [T_W-1:0] TINY_MAX  = T_W'((1 << TIME_FRAC_BITS) / 1000);
   localparam logic [T_W-1:0] T_MAX     = '1;

   localparam logic [DIST_W-1:0] TELEPORT_RESET = DIST_W'(1000);
   localparam logic [T_W-1:0]    MAX_EXTRAP_RESET = T_W'(2048);

   localparam int FLAG_ID     = 0;
   localparam int FLAG_FIRST  = 1;
   localparam int FLAG_MOVING = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TELEPORT   = 1'b0,
      CSR_MAX_EXTRAP = 1'b1
   } esi_csr_type;

   typedef enum logic [2:0] {
      OUT_NO_ID    = 3'd0,
      OUT_WAITING  = 3'd1,
      OUT_TELEPORT = 3'd2,
      OUT_INTERP   = 3'd3,
      OUT_EXTRAP   = 3'd4,
      OUT_HELD     = 3'd5
   } esi_outcome_type;

   typedef struct packed {
      logic [2:0]              entity_flags;
      logic [T_W-1:0]          delta_time;
      logic [T_W-1:0]          time_since_update;
      logic [T_W-1:0]          expected_interval;
      logic [T_W-1:0]          blend_alpha;
      logic signed [YAW_W-1:0] previous_yaw;
      logic signed [YAW_W-1:0] target_yaw;
      logic [POS_W-1:0]        current_position;
      logic [POS_W-1:0]        previous_position;
      logic [POS_W-1:0]        target_position;
      logic [POS_W-1:0]        target_velocity;
   } esi_req_type;

   typedef struct packed {
      esi_outcome_type         outcome;
      logic [POS_W-1:0]        new_position;
      logic signed [YAW_W-1:0] new_yaw;
      logic [T_W-1:0]          new_alpha;
      logic [T_W-1:0]          new_time_since_update;
      logic                    stale_warning;
   } esi_rsp_type;

   typedef struct packed {
      logic [2:0]              flags;
      logic [T_W-1:0]          alpha;
      logic [T_W-1:0]          interval;
      logic [T_W-1:0]          age;
      logic                    stale;
      logic                    tiny;
      logic                    ovf;
      logic signed [YAW_W-1:0] prev_yaw;
      logic signed [YAW_W-1:0] tgt_yaw;
      logic [POS_W-1:0]        cur;
      logic [POS_W-1:0]        prv;
      logic [POS_W-1:0]        tgt;
      logic [POS_W-1:0]        vel;
      esi_outcome_type         outcome;
      logic [T_W-1:0]          new_alpha;
      logic signed [T_W+1:0]   et;
   } esi_ctx_type;

   function automatic logic signed [COORD_BITS-1:0] get_coord(
      input logic [POS_W-1:0] p,
      input int unsigned      k
   );
      return p[k*COORD_BITS +: COORD_BITS];
   endfunction

endpackage

`default_nettype wire

### sv/entity_snapshot_interpolator_top.sv
// entity snapshot interpolator: requests pass a register pipeline from start to rsp_valid
// one request per cycle sustained, busy is never raised; the fixed depth is set
// by the four-stage divider and the four-stage smoothstep and multiply row
// results come out as one-cycle strobes, the receiver cannot stall
// synchronous active-high reset clears the valid pipe and loads register defaults
`default_nettype none

module entity_snapshot_interpolator_top
   import esi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire esi_req_type           req_data,
   // result strobe
   output logic                       rsp_valid,
   output esi_rsp_type                rsp_data,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // pipeline depth, stage 1 holds the raw request
   localparam int LAT = 10;

   logic [DIST_W-1:0] teleport_ff;
   logic [T_W-1:0]    max_extrap_ff;

   logic [LAT:1]      vld_ff;
   esi_req_type       req_ff;
   esi_ctx_type       ctx_ff [2:LAT];
   logic              tele_ff;

   esi_ctx_type       ctx2_in;
   esi_ctx_type       ctx6_in;
   logic [T_W-1:0]    quotient;
   logic              teleport;
   logic [POS_W-1:0]  blend_pos;
   logic signed [YAW_W-1:0] blend_yaw;

   logic [T_W:0]      age_sum;
   logic [T_W:0]      alpha_sum;
   logic [T_W-1:0]    alpha_adv;
   logic signed [T_W+1:0] et;

   // fully pipelined, never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         teleport_ff   <= TELEPORT_RESET;
         max_extrap_ff <= MAX_EXTRAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TELEPORT:   teleport_ff   <= csr_data;
            CSR_MAX_EXTRAP: max_extrap_ff <= csr_data[T_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 2: age, stale flag, tiny interval and divider overflow checks
   always_comb begin
      age_sum = {1'b0, req_ff.time_since_update} + {1'b0, req_ff.delta_time};
      ctx2_in = '0;
      ctx2_in.flags    = req_ff.entity_flags;
      ctx2_in.alpha    = req_ff.blend_alpha;
      ctx2_in.interval = req_ff.expected_interval;
      ctx2_in.prev_yaw = req_ff.previous_yaw;
      ctx2_in.tgt_yaw  = req_ff.target_yaw;
      ctx2_in.cur      = req_ff.current_position;
      ctx2_in.prv      = req_ff.previous_position;
      ctx2_in.tgt      = req_ff.target_position;
      ctx2_in.vel      = req_ff.target_velocity;
      ctx2_in.outcome  = OUT_NO_ID;
      // entities without id keep their age
      if (!req_ff.entity_flags[FLAG_ID]) begin
         ctx2_in.age = req_ff.time_since_update;
      end else if (age_sum[T_W]) begin
         ctx2_in.age = T_MAX;
      end else begin
         ctx2_in.age = age_sum[T_W-1:0];
      end
      ctx2_in.stale = req_ff.entity_flags[FLAG_ID] && !req_ff.entity_flags[FLAG_FIRST]
                      && (ctx2_in.age > STALE_AGE);
      ctx2_in.tiny  = req_ff.expected_interval <= TINY_MAX;
      // quotient reaches 2^16 when dt >= interval << (16 - frac)
      ctx2_in.ovf   = ((2*T_W)'(req_ff.delta_time)) >=
                      ((2*T_W)'(req_ff.expected_interval) << (T_W - TIME_FRAC_BITS));
   end

   // stage 6: new alpha, extrapolation time and outcome
   always_comb begin
      ctx6_in   = ctx_ff[5];
      alpha_sum = {1'b0, ctx_ff[5].alpha} + {1'b0, quotient};
      if (ctx_ff[5].tiny) begin
         alpha_adv = ONE_T;
      end else if (ctx_ff[5].ovf || alpha_sum[T_W]) begin
         alpha_adv = T_MAX;
      end else begin
         alpha_adv = alpha_sum[T_W-1:0];
      end

      // signed compare, a negative time stays below the cap
      et = (T_W+2)'(ctx_ff[5].age) - (T_W+2)'(ctx_ff[5].interval);
      if (et > $signed({2'b00, max_extrap_ff})) begin
         et = $signed({2'b00, max_extrap_ff});
      end
      ctx6_in.et = et;

      if (!ctx_ff[5].flags[FLAG_ID]) begin
         ctx6_in.outcome   = OUT_NO_ID;
         ctx6_in.new_alpha = ctx_ff[5].alpha;
      end else if (!ctx_ff[5].flags[FLAG_FIRST]) begin
         ctx6_in.outcome   = OUT_WAITING;
         ctx6_in.new_alpha = ctx_ff[5].alpha;
      end else if (tele_ff) begin
         ctx6_in.outcome   = OUT_TELEPORT;
         ctx6_in.new_alpha = ONE_T;
      end else if (alpha_adv < ONE_T) begin
         ctx6_in.outcome   = OUT_INTERP;
         ctx6_in.new_alpha = alpha_adv;
      end else if (et > 0 && ctx_ff[5].flags[FLAG_MOVING]) begin
         ctx6_in.outcome   = OUT_EXTRAP;
         ctx6_in.new_alpha = alpha_adv;
      end else begin
         ctx6_in.outcome   = OUT_HELD;
         ctx6_in.new_alpha = alpha_adv;
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start && !busy};
      end
   end

   // payload pipe
   always_ff @(posedge clock) begin
      req_ff    <= req_data;
      ctx_ff[2] <= ctx2_in;
      ctx_ff[3] <= ctx_ff[2];
      ctx_ff[4] <= ctx_ff[3];
      ctx_ff[5] <= ctx_ff[4];
      tele_ff   <= teleport;
      ctx_ff[6] <= ctx6_in;
      for (int i = 7; i <= LAT; i++) begin
         ctx_ff[i] <= ctx_ff[i-1];
      end
   end

   // alpha step divider, operands from stage 1, quotient at stage 5
   esi_div u_div (
      .clock      (clock),
      .delta_time (req_ff.delta_time),
      .interval   (req_ff.expected_interval),
      .quotient   (quotient)
   );

   // distance check, operands from stage 1, flag at stage 4
   esi_dist u_dist (
      .clock             (clock),
      .cur               (req_ff.current_position),
      .tgt               (req_ff.target_position),
      .teleport_distance (teleport_ff),
      .teleport          (teleport)
   );

   // blend, operands from stage 6, results at stage 10
   esi_blend u_blend (
      .clock    (clock),
      .interp   (ctx_ff[6].outcome == OUT_INTERP),
      .alpha    (ctx_ff[6].new_alpha),
      .et       (ctx_ff[6].et),
      .prv      (ctx_ff[6].prv),
      .tgt      (ctx_ff[6].tgt),
      .vel      (ctx_ff[6].vel),
      .prev_yaw (ctx_ff[6].prev_yaw),
      .tgt_yaw  (ctx_ff[6].tgt_yaw),
      .pos      (blend_pos),
      .yaw      (blend_yaw)
   );

   // result select
   always_comb begin
      rsp_data.outcome               = ctx_ff[LAT].outcome;
      rsp_data.new_alpha             = ctx_ff[LAT].new_alpha;
      rsp_data.new_time_since_update = ctx_ff[LAT].age;
      rsp_data.stale_warning         = ctx_ff[LAT].stale;
      unique case (ctx_ff[LAT].outcome) inside
         OUT_NO_ID, OUT_WAITING: begin
            rsp_data.new_position = ctx_ff[LAT].cur;
            rsp_data.new_yaw      = '0;
         end
         OUT_INTERP: begin
            rsp_data.new_position = blend_pos;
            rsp_data.new_yaw      = blend_yaw;
         end
         OUT_EXTRAP: begin
            rsp_data.new_position = blend_pos;
            rsp_data.new_yaw      = ctx_ff[LAT].tgt_yaw;
         end
         default: begin
            // teleport and held snap to target
            rsp_data.new_position = ctx_ff[LAT].tgt;
            rsp_data.new_yaw      = ctx_ff[LAT].tgt_yaw;
         end
      endcase
   end

   assign rsp_valid = vld_ff[LAT];

   `include "entity_snapshot_interpolator_top_assert.svh"

   // every request produces one strobe after the fixed latency
   `ESI_ASSERT_DLY(a_latency, start && !busy, LAT, rsp_valid)
   // a snap always resets alpha to one
   `ESI_ASSERT_IMP(a_tele_alpha, rsp_valid && rsp_data.outcome == OUT_TELEPORT, rsp_data.new_alpha == ONE_T)
   // stale flag only for entities waiting on their first update
   `ESI_ASSERT_IMP(a_stale_wait, rsp_valid && rsp_data.stale_warning, rsp_data.outcome == OUT_WAITING)
   // skipped entities report zero yaw
   `ESI_ASSERT_IMP(a_noid_yaw, rsp_valid && rsp_data.outcome == OUT_NO_ID, rsp_data.new_yaw == '0)

endmodule

`default_nettype wire

### sv/esi_div.sv
// pipelined restoring divider for the blend step, (dt << frac) / interval
// depends on esi_pkg; each stage registers its partial remainder and quotient
`default_nettype none

module esi_div
   import esi_pkg::*;
(
   input  wire logic           clock,
   input  wire logic [T_W-1:0] delta_time,
   input  wire logic [T_W-1:0] interval,
   output logic [T_W-1:0]      quotient
);

   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = T_W / BITS_PER_STAGE;

   logic [T_W:0]   rem_ff  [DIV_STAGES];
   logic [T_W-1:0] bits_ff [DIV_STAGES];
   logic [T_W-1:0] quo_ff  [DIV_STAGES];
   logic [T_W-1:0] den_ff  [DIV_STAGES];

   logic [T_W:0]   rem_in  [DIV_STAGES];
   logic [T_W-1:0] bits_in [DIV_STAGES];
   logic [T_W-1:0] quo_in  [DIV_STAGES];
   logic [T_W-1:0] den_in  [DIV_STAGES];

   always_comb begin
      logic [T_W:0]   r;
      logic [T_W-1:0] b;
      logic [T_W-1:0] q;
      logic [T_W:0]   sh;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            // high part of the dividend is below the divisor when no overflow
            r         = (T_W+1)'(delta_time >> (T_W - TIME_FRAC_BITS));
            b         = T_W'(delta_time << TIME_FRAC_BITS);
            q         = '0;
            den_in[s] = interval;
         end else begin
            r         = rem_ff[s-1];
            b         = bits_ff[s-1];
            q         = quo_ff[s-1];
            den_in[s] = den_ff[s-1];
         end
         for (int i = 0; i < BITS_PER_STAGE; i++) begin
            sh = {r[T_W-1:0], b[T_W-1]};
            b  = {b[T_W-2:0], 1'b0};
            if (sh >= {1'b0, den_in[s]}) begin
               r = sh - {1'b0, den_in[s]};
               q = {q[T_W-2:0], 1'b1};
            end else begin
               r = sh;
               q = {q[T_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = r;
         bits_in[s] = b;
         quo_in[s]  = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         bits_ff[s] <= bits_in[s];
         quo_ff[s]  <= quo_in[s];
         den_ff[s]  <= den_in[s];
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

### sv/esi_dist.sv
// teleport test: squared distance to target against threshold squared
// depends on esi_pkg; result registered through the difference, square and compare stages
`default_nettype none

module esi_dist
   import esi_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [POS_W-1:0]  cur,
   input  wire logic [POS_W-1:0]  tgt,
   input  wire logic [DIST_W-1:0] teleport_distance,
   output logic                   teleport
);

   localparam int DW   = COORD_BITS + 1;
   localparam int SQW  = 2 * COORD_BITS;
   localparam int SUMW = SQW + 2;
   localparam int TDW  = 2 * DIST_W;

   logic signed [DW-1:0] diff_ff [3];
   logic [SQW-1:0]       sq_ff   [3];
   logic [TDW-1:0]       td2_ff;
   logic                 tele_ff;

   logic signed [DW-1:0]   diff_in [3];
   logic [SQW-1:0]         sq_in   [3];
   logic signed [2*DW-1:0] prod;
   logic [SUMW-1:0]        sum;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = DW'(get_coord(cur, k)) - DW'(get_coord(tgt, k));
      end
      for (int k = 0; k < 3; k++) begin
         prod     = diff_ff[k] * diff_ff[k];
         sq_in[k] = prod[SQW-1:0];
      end
      sum = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= sq_in;
      td2_ff  <= TDW'(teleport_distance) * TDW'(teleport_distance);
      tele_ff <= sum > SUMW'(td2_ff);
   end

   assign teleport = tele_ff;

endmodule

`default_nettype wire

### sv/esi_blend.sv
// smoothstep interpolation and velocity extrapolation on a shared multiplier row
// depends on esi_pkg; results registered through the weight, multiplier, product and output stages
`default_nettype none

module esi_blend
   import esi_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    interp,
   input  wire logic [T_W-1:0]          alpha,
   input  wire logic signed [T_W+1:0]   et,
   input  wire logic [POS_W-1:0]        prv,
   input  wire logic [POS_W-1:0]        tgt,
   input  wire logic [POS_W-1:0]        vel,
   input  wire logic signed [YAW_W-1:0] prev_yaw,
   input  wire logic signed [YAW_W-1:0] tgt_yaw,
   output logic [POS_W-1:0]             pos,
   output logic signed [YAW_W-1:0]      yaw
);

   localparam int CW    = COORD_BITS;
   localparam int DW    = COORD_BITS + 1;
   localparam int TF    = TIME_FRAC_BITS;
   localparam int A2W   = 2 * TF;
   localparam int WW    = TF + 2;
   localparam int PW    = A2W + WW;
   localparam int SW    = TF + 1;
   localparam int MULW  = T_W + 1;
   localparam int MW    = DW + MULW + 1;
   localparam int YDW   = YAW_W + 1;
   localparam int YMW   = YDW + MULW + 1;

   localparam logic signed [MW-1:0]  HALF_M = MW'(1 << (TF - 1));
   localparam logic signed [YMW-1:0] HALF_Y = YMW'(1 << (TF - 1));
   localparam logic signed [MW-1:0]  CMAX   = MW'((1 << (CW - 1)) - 1);
   localparam logic signed [MW-1:0]  CMIN   = MW'(-(1 << (CW - 1)));
   localparam logic signed [YMW-1:0] YMAX   = YMW'((1 << (YAW_W - 1)) - 1);
   localparam logic signed [YMW-1:0] YMIN   = YMW'(-(1 << (YAW_W - 1)));
   localparam logic [WW-1:0]         THREE  = WW'(3 << TF);

   // stage one
   logic [A2W-1:0]        a2_ff;
   logic [WW-1:0]         w_ff;
   logic                  interp_ff;
   logic [T_W-1:0]        et1_ff;
   logic signed [DW-1:0]  op1_ff   [3];
   logic signed [CW-1:0]  base1_ff [3];
   logic signed [YDW-1:0] yd1_ff;
   logic signed [YAW_W-1:0] yb1_ff;
   // stage two
   logic [MULW-1:0]       mul_ff;
   logic signed [DW-1:0]  op2_ff   [3];
   logic signed [CW-1:0]  base2_ff [3];
   logic signed [YDW-1:0] yd2_ff;
   logic signed [YAW_W-1:0] yb2_ff;
   // stage three
   logic signed [MW-1:0]  m_ff     [3];
   logic signed [CW-1:0]  base3_ff [3];
   logic signed [YMW-1:0] ym_ff;
   logic signed [YAW_W-1:0] yb3_ff;
   // stage four
   logic [POS_W-1:0]      pos_ff;
   logic signed [YAW_W-1:0] yaw_ff;

   logic [TF-1:0]         a;
   logic signed [DW-1:0]  op_in   [3];
   logic signed [CW-1:0]  base_in [3];
   logic [PW-1:0]         prod;
   logic [SW-1:0]         s;
   logic [MULW-1:0]       mul_in;
   logic signed [MW-1:0]  m_in    [3];
   logic signed [YMW-1:0] ym_in;
   logic signed [MW-1:0]  rnd;
   logic signed [MW-1:0]  full;
   logic [POS_W-1:0]      pos_in;
   logic signed [YMW-1:0] yrnd;
   logic signed [YMW-1:0] yfull;
   logic signed [YAW_W-1:0] yaw_in;

   always_comb begin
      a = alpha[TF-1:0];
      for (int k = 0; k < 3; k++) begin
         if (interp) begin
            op_in[k]   = DW'(get_coord(tgt, k)) - DW'(get_coord(prv, k));
            base_in[k] = get_coord(prv, k);
         end else begin
            op_in[k]   = DW'(get_coord(vel, k));
            base_in[k] = get_coord(tgt, k);
         end
      end

      // smoothstep weight s = a*a*(3 - 2a)
      prod   = PW'(a2_ff) * PW'(w_ff);
      s      = prod[A2W +: SW];
      mul_in = interp_ff ? MULW'(s) : {1'b0, et1_ff};

      for (int k = 0; k < 3; k++) begin
         m_in[k] = op2_ff[k] * $signed({1'b0, mul_ff});
      end
      ym_in = yd2_ff * $signed({1'b0, mul_ff});

      // round half up, add base, saturate
      pos_in = '0;
      for (int k = 0; k < 3; k++) begin
         rnd  = (m_ff[k] + HALF_M) >>> TF;
         full = MW'(base3_ff[k]) + rnd;
         if (full > CMAX) begin
            full = CMAX;
         end else if (full < CMIN) begin
            full = CMIN;
         end
         pos_in[k*CW +: CW] = full[CW-1:0];
      end
      yrnd  = (ym_ff + HALF_Y) >>> TF;
      yfull = YMW'(yb3_ff) + yrnd;
      if (yfull > YMAX) begin
         yaw_in = YMAX[YAW_W-1:0];
      end else if (yfull < YMIN) begin
         yaw_in = YMIN[YAW_W-1:0];
      end else begin
         yaw_in = yfull[YAW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a2_ff     <= A2W'(a) * A2W'(a);
      w_ff      <= THREE - WW'({a, 1'b0});
      interp_ff <= interp;
      et1_ff    <= et[T_W-1:0];
      op1_ff    <= op_in;
      base1_ff  <= base_in;
      yd1_ff    <= YDW'(tgt_yaw) - YDW'(prev_yaw);
      yb1_ff    <= prev_yaw;

      mul_ff    <= mul_in;
      op2_ff    <= op1_ff;
      base2_ff  <= base1_ff;
      yd2_ff    <= yd1_ff;
      yb2_ff    <= yb1_ff;

      m_ff      <= m_in;
      base3_ff  <= base2_ff;
      ym_ff     <= ym_in;
      yb3_ff    <= yb2_ff;

      pos_ff    <= pos_in;
      yaw_ff    <= yaw_in;
   end

   assign pos = pos_ff;
   assign yaw = yaw_ff;

endmodule

`default_nettype wire
